FILE: sv/hcp_pkg.sv
`default_nettype none
package hcp_pkg;

  localparam int MAX_DIGITS = 8;
  localparam int DIGIT_W    = 4;
  localparam int COUNT_W    = $clog2(MAX_DIGITS + 1);
  localparam int INDEX_W    = $clog2(MAX_DIGITS);

  localparam logic [7:0] CHAR_TAB   = 8'd9;
  localparam logic [7:0] CHAR_SPACE = 8'd32;
  localparam logic [7:0] CHAR_HASH  = 8'd35;
  localparam logic [7:0] CHAR_0     = 8'd48;
  localparam logic [7:0] CHAR_9     = 8'd57;
  localparam logic [7:0] CHAR_UA    = 8'd65;
  localparam logic [7:0] CHAR_UF    = 8'd70;
  localparam logic [7:0] CHAR_LA    = 8'd97;
  localparam logic [7:0] CHAR_LF    = 8'd102;

  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

  typedef enum logic [1:0] {
    PH_LEAD,
    PH_DIGITS,
    PH_TRAIL
  } phase_t;

  typedef struct packed {
    logic               is_hex;
    logic [DIGIT_W-1:0] value;
  } hex_t;

  // parser state as seen by the result stage on an end-of-text transaction
  typedef struct packed {
    logic                                failed;
    logic [COUNT_W-1:0]                  count;
    logic [MAX_DIGITS-1:0][DIGIT_W-1:0]  digits;
  } snap_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CHAR_SPACE) || (c == CHAR_TAB);
  endfunction

  function automatic hex_t hex_value(input logic [7:0] c);
    hex_t h;
    logic [7:0] t;
    h.is_hex = 1'b1;
    h.value  = '0;
    t        = '0;
    if (c >= CHAR_0 && c <= CHAR_9) begin
      t = c - CHAR_0;
    end else if (c >= CHAR_LA && c <= CHAR_LF) begin
      t = c - CHAR_LA + 8'd10;
    end else if (c >= CHAR_UA && c <= CHAR_UF) begin
      t = c - CHAR_UA + 8'd10;
    end else begin
      h.is_hex = 1'b0;
    end
    h.value = t[DIGIT_W-1:0];
    return h;
  endfunction

endpackage
`default_nettype wire

FILE: sv/hcp_in_if.sv
`default_nettype none
interface hcp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       end_of_text;

  modport source (output valid, output ch, output end_of_text, input ready);
  modport sink   (input valid, input ch, input end_of_text, output ready);
endinterface
`default_nettype wire

FILE: sv/hcp_out_if.sv
`default_nettype none
interface hcp_out_if;
  logic       valid;
  logic       ready;
  logic       valid_res;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       alpha_given;
  logic [7:0] alpha;

  modport source (output valid, output valid_res, output red, output green, output blue,
                  output alpha_given, output alpha, input ready);
  modport sink   (input valid, input valid_res, input red, input green, input blue,
                  input alpha_given, input alpha, output ready);
endinterface
`default_nettype wire

FILE: sv/hcp_scan.sv
`default_nettype none
module hcp_scan (
  input  wire logic          clk,
  input  wire logic          rst,
  hcp_in_if.sink             chars,
  input  wire logic          eot_take,
  output logic               eot_fire,
  output hcp_pkg::snap_t     snap
);
  import hcp_pkg::*;

  logic       s1_valid;
  logic [7:0] s1_ch;
  logic       s1_eot;
  logic       advance;

  phase_t                               phase, phase_next;
  logic [COUNT_W-1:0]                   count, count_next;
  logic                                 failed, failed_next;
  logic [MAX_DIGITS-1:0][DIGIT_W-1:0]   digits;
  logic                                 store_en;
  logic [DIGIT_W-1:0]                   store_val;
  hex_t                                 hx;

  // only an end-of-text transaction can be held back by the result side
  assign advance     = s1_valid && (!s1_eot || eot_take);
  assign chars.ready = !s1_valid || advance;
  assign eot_fire    = advance && s1_eot;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (chars.valid && chars.ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (chars.valid && chars.ready) begin
      s1_ch  <= chars.ch;
      s1_eot <= chars.end_of_text;
    end
  end

  always_comb begin
    phase_next  = phase;
    count_next  = count;
    failed_next = failed;
    store_en    = 1'b0;
    hx          = hex_value(s1_ch);
    store_val   = hx.value;
    if (advance) begin
      if (s1_eot) begin
        phase_next  = PH_LEAD;
        count_next  = '0;
        failed_next = 1'b0;
      end else if (!failed) begin
        case (phase)
          PH_LEAD: begin
            if (is_blank(s1_ch)) begin
              phase_next = PH_LEAD;
            end else if (s1_ch == CHAR_HASH) begin
              phase_next = PH_DIGITS;
            end else if (hx.is_hex) begin
              phase_next = PH_DIGITS;
              store_en   = 1'b1;
            end else begin
              failed_next = 1'b1;
            end
          end
          PH_DIGITS: begin
            if (is_blank(s1_ch)) begin
              phase_next = PH_TRAIL;
            end else if (hx.is_hex) begin
              store_en = 1'b1;
            end else begin
              failed_next = 1'b1;
            end
          end
          default: begin
            if (!is_blank(s1_ch)) failed_next = 1'b1;
          end
        endcase
        if (store_en) begin
          if (count >= COUNT_W'(MAX_DIGITS)) begin
            failed_next = 1'b1;
            store_en    = 1'b0;
          end else begin
            count_next = count + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_LEAD;
      count  <= '0;
      failed <= 1'b0;
    end else begin
      phase  <= phase_next;
      count  <= count_next;
      failed <= failed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (store_en) digits[count[INDEX_W-1:0]] <= store_val;
  end

  assign snap.failed = failed;
  assign snap.count  = count;
  assign snap.digits = digits;

endmodule
`default_nettype wire

FILE: sv/hcp_result.sv
`default_nettype none
module hcp_result (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          eot_fire,
  input  wire hcp_pkg::snap_t snap,
  output logic               eot_take,
  hcp_out_if.source          result
);
  import hcp_pkg::*;

  logic       res_valid;
  logic       ok;
  logic       ag;
  logic [7:0] v0, v1, v2, v3;
  logic       short_form;
  logic       long_form;

  assign eot_take = !res_valid || result.ready;

  always_comb begin
    short_form = !snap.failed && (snap.count inside {COUNT_W'(3), COUNT_W'(4)});
    long_form  = !snap.failed && (snap.count inside {COUNT_W'(6), COUNT_W'(8)});
    ok = short_form || long_form;
    ag = 1'b0;
    v0 = '0;
    v1 = '0;
    v2 = '0;
    v3 = ALPHA_OPAQUE;
    // times 17 is the nibble repeated in both halves of the byte
    if (short_form) begin
      v0 = {snap.digits[0], snap.digits[0]};
      v1 = {snap.digits[1], snap.digits[1]};
      v2 = {snap.digits[2], snap.digits[2]};
      if (snap.count == COUNT_W'(4)) begin
        v3 = {snap.digits[3], snap.digits[3]};
        ag = 1'b1;
      end
    end else if (long_form) begin
      v0 = {snap.digits[0], snap.digits[1]};
      v1 = {snap.digits[2], snap.digits[3]};
      v2 = {snap.digits[4], snap.digits[5]};
      if (snap.count == COUNT_W'(8)) begin
        v3 = {snap.digits[6], snap.digits[7]};
        ag = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (eot_fire) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (eot_fire) begin
      result.valid_res   <= ok;
      result.red         <= v0;
      result.green       <= v1;
      result.blue        <= v2;
      result.alpha_given <= ag;
      result.alpha       <= v3;
    end
  end

  assign result.valid = res_valid;

endmodule
`default_nettype wire

FILE: sv/hex_color_text_parser.sv
`default_nettype none
// Hex colour text parser: one character transaction per cycle.
// An end-of-text transaction gives its result by way of the input register, which
// hands it to the result register once that register is free or being read out.
// Throughput: one character every cycle; end-of-text waits only while a result is held.
// Reset (rst, synchronous) clears phase, digit count, failure flag and valids;
// the digit store is not reset.
module hex_color_text_parser (
  input  wire logic clk,
  input  wire logic rst,
  hcp_in_if.sink    chars,
  hcp_out_if.source result
);
  import hcp_pkg::*;

  logic  eot_take;
  logic  eot_fire;
  snap_t snap;

  hcp_scan u_scan (
    .clk      (clk),
    .rst      (rst),
    .chars    (chars),
    .eot_take (eot_take),
    .eot_fire (eot_fire),
    .snap     (snap)
  );

  hcp_result u_result (
    .clk      (clk),
    .rst      (rst),
    .eot_fire (eot_fire),
    .snap     (snap),
    .eot_take (eot_take),
    .result   (result)
  );

endmodule
`default_nettype wire

FILE: bench/tb_hex_color_text_parser.sv
module tb_hex_color_text_parser;
  import hcp_pkg::*;

  typedef struct packed {
    logic       valid_res;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       alpha_given;
    logic [7:0] alpha;
  } colour_t;

  // one directed string; text is right-justified, so NUL can be written as a byte
  typedef struct {
    int          len;
    logic [95:0] text;
    bit          typed;
    colour_t     want;
  } text_row_t;

  localparam colour_t NO_COLOUR    = {1'b0, 24'd0, 1'b0, ALPHA_OPAQUE};
  localparam int      RANDOM_ITEMS = 1850;
  localparam int      CALM_ITEMS   = 250;
  localparam int      STALL_LIMIT  = 1000;
  localparam int      PRINT_LIMIT  = 40;

  logic clk = 1'b0;
  logic rst;

  hcp_in_if  chars_if ();
  hcp_out_if res_if ();

  hex_color_text_parser u_top (
    .clk    (clk),
    .rst    (rst),
    .chars  (chars_if),
    .result (res_if)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  phase_t      shadow_phase;
  int unsigned shadow_count;
  logic [3:0]  shadow_digits [MAX_DIGITS];
  bit          shadow_failed;

  colour_t     expected_colours [$];
  logic [7:0]  text_buf [$];
  int          mismatches;
  int          items_sent;
  int          strings_sent;
  int          colours_seen;
  int          good_colours;
  bit          calm;
  int unsigned stall_left;
  int unsigned quiet_cycles;

  function automatic bit decode_hex(input logic [7:0] c, output logic [3:0] nib);
    nib = c[3:0];
    if (c >= CHAR_0 && c <= CHAR_9) return 1'b1;
    // 'a' and 'A' both end in nibble 1, so adding 9 lands on 10
    nib = c[3:0] + 4'd9;
    return (c >= CHAR_LA && c <= CHAR_LF) || (c >= CHAR_UA && c <= CHAR_UF);
  endfunction

  // steps the shadow parser; the return value only means something on end of text
  function automatic colour_t advance_parser(input logic [7:0] c, input logic eot);
    colour_t    col;
    logic [3:0] nib;
    bit         is_hex;
    bit         blank;
    col = NO_COLOUR;
    if (eot) begin
      if (!shadow_failed) begin
        case (shadow_count)
          3, 4: begin
            col.valid_res = 1'b1;
            col.red       = {shadow_digits[0], shadow_digits[0]};
            col.green     = {shadow_digits[1], shadow_digits[1]};
            col.blue      = {shadow_digits[2], shadow_digits[2]};
            if (shadow_count == 4) begin
              col.alpha_given = 1'b1;
              col.alpha       = {shadow_digits[3], shadow_digits[3]};
            end
          end
          6, 8: begin
            col.valid_res = 1'b1;
            col.red       = {shadow_digits[0], shadow_digits[1]};
            col.green     = {shadow_digits[2], shadow_digits[3]};
            col.blue      = {shadow_digits[4], shadow_digits[5]};
            if (shadow_count == 8) begin
              col.alpha_given = 1'b1;
              col.alpha       = {shadow_digits[6], shadow_digits[7]};
            end
          end
          default: ;
        endcase
      end
      shadow_phase  = PH_LEAD;
      shadow_count  = 0;
      shadow_failed = 1'b0;
      return col;
    end
    if (shadow_failed) return col;
    is_hex = decode_hex(c, nib);
    blank  = (c == CHAR_SPACE) || (c == CHAR_TAB);
    if (shadow_phase == PH_TRAIL || blank) begin
      if (!blank) shadow_failed = 1'b1;
      else if (shadow_phase != PH_LEAD) shadow_phase = PH_TRAIL;
    end else if (is_hex) begin
      if (shadow_count == MAX_DIGITS) begin
        shadow_failed = 1'b1;
      end else begin
        shadow_digits[shadow_count] = nib;
        shadow_count++;
      end
      shadow_phase = PH_DIGITS;
    end else if (c == CHAR_HASH && shadow_phase == PH_LEAD) begin
      shadow_phase = PH_DIGITS;
    end else begin
      shadow_failed = 1'b1;
    end
    return col;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= PRINT_LIMIT)
      $display("MISMATCH result %0d %s: got %0d, want %0d", colours_seen, what, got, want);
  endtask

  // called at a falling edge; returns at the falling edge after the transaction
  task automatic send_item(input logic [7:0] c, input logic eot, input bit typed,
                           input colour_t want);
    colour_t predicted;
    if (!calm && $urandom_range(0, 5) == 0) begin
      chars_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    chars_if.valid       <= 1'b1;
    chars_if.ch          <= c;
    chars_if.end_of_text <= eot;
    do @(posedge clk); while (!chars_if.ready);
    predicted = advance_parser(c, eot);
    if (eot) expected_colours.push_back(typed ? want : predicted);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_buffered(input bit typed, input colour_t want);
    foreach (text_buf[i]) send_item(text_buf[i], 1'b0, 1'b0, NO_COLOUR);
    send_item(8'($urandom_range(0, 255)), 1'b1, typed, want);
    strings_sent++;
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 2);
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    colour_t got;
    colour_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      got = {res_if.valid_res, res_if.red, res_if.green, res_if.blue,
             res_if.alpha_given, res_if.alpha};
      if (expected_colours.size() == 0) begin
        report_mismatch("unexpected transaction, valid_res", got.valid_res, 0);
      end else begin
        want = expected_colours.pop_front();
        if (got.valid_res !== want.valid_res)
          report_mismatch("valid_res", got.valid_res, want.valid_res);
        if (got.red !== want.red) report_mismatch("red", got.red, want.red);
        if (got.green !== want.green) report_mismatch("green", got.green, want.green);
        if (got.blue !== want.blue) report_mismatch("blue", got.blue, want.blue);
        if (got.alpha_given !== want.alpha_given)
          report_mismatch("alpha_given", got.alpha_given, want.alpha_given);
        if (got.alpha !== want.alpha) report_mismatch("alpha", got.alpha, want.alpha);
      end
      colours_seen++;
      if (got.valid_res === 1'b1) good_colours++;
    end
  end

  always @(posedge clk) begin
    if ((chars_if.valid && chars_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("Timed out: %0d cycles without a transaction", STALL_LIMIT);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    text_row_t   rows [10];
    int          total;
    int          kind;
    int          n;
    int          v;
    int          pos;
    logic [7:0]  junk;

    rst                  = 1'b1;
    chars_if.valid       = 1'b0;
    chars_if.ch          = 8'd0;
    chars_if.end_of_text = 1'b0;
    res_if.ready         = 1'b0;
    shadow_phase         = PH_LEAD;
    shadow_count         = 0;
    shadow_failed        = 1'b0;
    mismatches           = 0;
    items_sent           = 0;
    strings_sent         = 0;
    colours_seen         = 0;
    good_colours         = 0;
    calm                 = 1'b0;
    stall_left           = 0;
    quiet_cycles         = 0;

    rows[0] = '{0, 96'd0, 1'b1, NO_COLOUR};
    rows[1] = '{7, 96'(" \t#fFf\t"), 1'b1, {1'b1, 8'hff, 8'hff, 8'hff, 1'b0, 8'hff}};
    rows[2] = '{4, 96'("0000"), 1'b1, {1'b1, 8'h00, 8'h00, 8'h00, 1'b1, 8'h00}};
    rows[3] = '{8, 96'("FFFFFFFF"), 1'b1, {1'b1, 8'hff, 8'hff, 8'hff, 1'b1, 8'hff}};
    rows[4] = '{6, 96'("aB9c8D"), 1'b0, NO_COLOUR};
    rows[5] = '{2, 96'("##"), 1'b1, NO_COLOUR};
    rows[6] = '{1, 96'h0, 1'b1, NO_COLOUR};              // lone NUL
    rows[7] = '{5, 96'("123 4"), 1'b1, NO_COLOUR};       // digit after trailing blank
    rows[8] = '{5, 96'("Ag123"), 1'b1, NO_COLOUR};       // rest ignored once failed
    rows[9] = '{9, 96'("FFFFFFFF0"), 1'b1, NO_COLOUR};   // one digit too many

    repeat (2) @(negedge clk);
    rst <= 1'b0;

    foreach (rows[r]) begin
      text_buf.delete();
      for (int i = 0; i < rows[r].len; i++)
        text_buf.push_back(rows[r].text[8*(rows[r].len-1-i) +: 8]);
      send_buffered(rows[r].typed, rows[r].want);
    end

    total = items_sent + RANDOM_ITEMS;
    while (items_sent < total) begin
      calm = (items_sent > total - CALM_ITEMS);
      text_buf.delete();
      kind = $urandom_range(0, 99);
      if (kind < 10) begin
        repeat ($urandom_range(0, 6)) text_buf.push_back(8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(0, 3)) text_buf.push_back($urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB);
        if ($urandom_range(0, 1)) text_buf.push_back(CHAR_HASH);
        if ($urandom_range(0, 4) == 0) begin
          n = $urandom_range(0, 10);
        end else begin
          case ($urandom_range(0, 3))
            0:       n = 3;
            1:       n = 4;
            2:       n = 6;
            default: n = 8;
          endcase
        end
        repeat (n) begin
          v = $urandom_range(0, 15);
          if (v < 10) text_buf.push_back(8'(CHAR_0 + v));
          else text_buf.push_back(8'(($urandom_range(0, 1) ? CHAR_LA : CHAR_UA) + v - 10));
        end
        repeat ($urandom_range(0, 2)) text_buf.push_back($urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB);
        // break about a quarter of the well-formed strings with one stray byte
        if (kind < 32) begin
          pos  = $urandom_range(0, text_buf.size());
          junk = ($urandom_range(0, 3) == 0) ? CHAR_HASH : 8'($urandom_range(0, 255));
          if (pos == text_buf.size()) text_buf.push_back(junk);
          else text_buf[pos] = junk;
        end
      end
      send_buffered(1'b0, NO_COLOUR);
    end

    chars_if.valid <= 1'b0;
    while (expected_colours.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);

    $display("Drove %0d character and end-of-text transactions over %0d strings.",
             items_sent, strings_sent);
    $display("Checked %0d colour results, %0d of them well formed.", colours_seen, good_colours);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
